// ===== hw/rtl/mcpct_pkg.sv =====
`default_nettype none
package mcpct_pkg;

  localparam int CHANNELS = 5;
  localparam int TIMER_W  = 16;
  localparam int PS_W     = 3;
  localparam int CH_IDX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ARM   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MASK = 3'd6;

  typedef struct packed {
    logic [1:0]                        prescale_sel;
    logic [CHANNELS-1:0][TIMER_W-1:0]  inc;
    logic [CHANNELS-1:0]               irq_mask;
  } cfg_t;

  typedef struct packed {
    logic [TIMER_W-1:0]  count;
    logic [CHANNELS-1:0] flags;
    logic [CHANNELS-1:0] matched;
    logic                irq;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mcpct_cfg_regs.sv =====
`default_nettype none
module mcpct_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 wr_en,
  input  wire logic [mcpct_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire logic [mcpct_pkg::CFG_DATA_W-1:0]     wr_data,
  output mcpct_pkg::cfg_t                           cfg
);

  mcpct_pkg::cfg_t cfg_r;
  mcpct_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      if (wr_index == mcpct_pkg::CFG_PRESCALE) begin
        cfg_nxt.prescale_sel = wr_data[1:0];
      end
      if (wr_index == mcpct_pkg::CFG_IRQ_MASK) begin
        cfg_nxt.irq_mask = wr_data[mcpct_pkg::CHANNELS-1:0];
      end
      for (int i = 0; i < mcpct_pkg::CHANNELS; i++) begin
        if (wr_index == mcpct_pkg::CFG_INC0 + mcpct_pkg::CFG_IDX_W'(i)) begin
          cfg_nxt.inc[i] = wr_data[mcpct_pkg::TIMER_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mcpct_core.sv =====
`default_nettype none
module mcpct_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               fire,
  input  wire logic [1:0]                         action,
  input  wire logic [mcpct_pkg::CH_IDX_W-1:0]     channel,
  input  mcpct_pkg::cfg_t                         cfg,
  output mcpct_pkg::res_t                         res
);

  localparam int CW = mcpct_pkg::TIMER_W;
  localparam int NC = mcpct_pkg::CHANNELS;

  logic [CW-1:0]                timer_r, timer_nxt;
  logic [mcpct_pkg::PS_W-1:0]   ps_cnt_r, ps_cnt_nxt;
  logic [NC-1:0][CW-1:0]        mp_r, mp_nxt;
  logic [NC-1:0]                flags_r, flags_nxt;
  logic [NC-1:0]                matched;
  logic [CW-1:0]                timer_inc;
  logic [mcpct_pkg::PS_W:0]     ps_plus1;
  logic [mcpct_pkg::PS_W:0]     divider;

  assign timer_inc = timer_r + CW'(1);
  assign ps_plus1  = {1'b0, ps_cnt_r} + (mcpct_pkg::PS_W+1)'(1);
  assign divider   = (mcpct_pkg::PS_W+1)'(1) << cfg.prescale_sel;

  always_comb begin
    timer_nxt  = timer_r;
    ps_cnt_nxt = ps_cnt_r;
    mp_nxt     = mp_r;
    flags_nxt  = flags_r;
    matched    = '0;
    case (action)
      mcpct_pkg::ACT_TICK: begin
        if (ps_plus1 >= divider) begin
          ps_cnt_nxt = '0;
          timer_nxt  = timer_inc;
          for (int i = 0; i < NC; i++) begin
            if (mp_r[i] == timer_inc) begin
              matched[i] = 1'b1;
              mp_nxt[i]  = mp_r[i] + cfg.inc[i];
            end
          end
          flags_nxt = flags_r | matched;
        end else begin
          ps_cnt_nxt = ps_plus1[mcpct_pkg::PS_W-1:0];
        end
      end
      mcpct_pkg::ACT_ARM: begin
        for (int i = 0; i < NC; i++) begin
          if (channel == mcpct_pkg::CH_IDX_W'(i)) begin
            mp_nxt[i] = timer_r + cfg.inc[i];
          end
        end
      end
      mcpct_pkg::ACT_CLEAR: begin
        for (int i = 0; i < NC; i++) begin
          if (channel == mcpct_pkg::CH_IDX_W'(i)) begin
            flags_nxt[i] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= '0;
      ps_cnt_r <= '0;
      mp_r     <= '0;
      flags_r  <= '0;
    end else if (fire) begin
      timer_r  <= timer_nxt;
      ps_cnt_r <= ps_cnt_nxt;
      mp_r     <= mp_nxt;
      flags_r  <= flags_nxt;
    end
  end

  assign res.count   = timer_nxt;
  assign res.flags   = flags_nxt;
  assign res.matched = matched;
  assign res.irq     = |(flags_nxt & cfg.irq_mask);

endmodule
`default_nettype wire

// ===== hw/rtl/multi_channel_periodic_compare_timer_unit.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_stall    | in_action[1:0], in_channel[2:0]
// out     | output    | out_valid / out_stall  | out_count, out_flags, out_matched_now, out_irq
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[15:0]
//
// One transaction per cycle sustained while out_stall is low; an accepted transaction goes into the
// input register, then through one pass of the compare/add logic into the result register.
// Synchronous active-low reset clears timer, prescaler, match points, flags and config.
// A stalled result holds; the input register keeps accepting while the result register
// can advance, so in_stall rises only when both are occupied and out_stall is high.
// cfg_ready is always high.
`default_nettype none
module multi_channel_periodic_compare_timer_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic [1:0]                            in_action,
  input  wire logic [mcpct_pkg::CH_IDX_W-1:0]        in_channel,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic [mcpct_pkg::TIMER_W-1:0]         out_count,
  output      logic [mcpct_pkg::CHANNELS-1:0]        out_flags,
  output      logic [mcpct_pkg::CHANNELS-1:0]        out_matched_now,
  output      logic                                  out_irq,
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic [mcpct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mcpct_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mcpct_pkg::cfg_t cfg;
  mcpct_pkg::res_t res;
  mcpct_pkg::res_t res_r;

  logic                               in_valid_r;
  logic [1:0]                         in_action_r;
  logic [mcpct_pkg::CH_IDX_W-1:0]     in_channel_r;
  logic                               out_valid_r;
  logic                               advance;
  logic                               fire;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;

  mcpct_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mcpct_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .action  (in_action_r),
    .channel (in_channel_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action_r  <= in_action;
      in_channel_r <= in_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_count       = res_r.count;
  assign out_flags       = res_r.flags;
  assign out_matched_now = res_r.matched;
  assign out_irq         = res_r.irq;

endmodule
`default_nettype wire

// ===== hw/rtl/mcpct_checker.sv =====
`default_nettype none
module mcpct_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic [mcpct_pkg::TIMER_W-1:0]         out_count,
  input wire logic [mcpct_pkg::CHANNELS-1:0]        out_flags,
  input wire logic [mcpct_pkg::CHANNELS-1:0]        out_matched_now,
  input wire logic                                  out_irq
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count) && $stable(out_flags)
      && $stable(out_matched_now) && $stable(out_irq))
    else $error("stalled result transaction changed");

  a_match_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_matched_now & ~out_flags) == '0)
    else $error("matched channel without pending flag");

  a_irq_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flags == '0 |-> !out_irq)
    else $error("irq raised with no pending flag");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind multi_channel_periodic_compare_timer_unit mcpct_checker u_mcpct_checker (.*);
`default_nettype wire

// ===== dv/compare_timer_checker.sv =====
`timescale 1ns / 1ps
module compare_timer_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [mcpct_pkg::CH_IDX_W-1:0]     in_channel,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [mcpct_pkg::TIMER_W-1:0]      out_count,
  input  logic [mcpct_pkg::CHANNELS-1:0]     out_flags,
  input  logic [mcpct_pkg::CHANNELS-1:0]     out_matched_now,
  input  logic                               out_irq,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mcpct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcpct_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked,
  output int                                 match_events
);

  mcpct_pkg::cfg_t                   regs;
  logic [mcpct_pkg::TIMER_W-1:0]     count_q;
  logic [mcpct_pkg::PS_W-1:0]        presc_q;
  logic [mcpct_pkg::TIMER_W-1:0]     match_at [mcpct_pkg::CHANNELS];
  logic [mcpct_pkg::CHANNELS-1:0]    flags_q;
  mcpct_pkg::res_t                   timer_snapshots [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    checked      = 0;
    match_events = 0;
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", field, got, want, $time);
    fail_count = fail_count + 1;
  endtask

  task automatic apply_reg(input logic [mcpct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcpct_pkg::CFG_DATA_W-1:0] data);
    if (idx == mcpct_pkg::CFG_PRESCALE) begin
      regs.prescale_sel = data[1:0];
    end else if (idx == mcpct_pkg::CFG_IRQ_MASK) begin
      regs.irq_mask = data[mcpct_pkg::CHANNELS-1:0];
    end else if (idx >= mcpct_pkg::CFG_INC0 &&
                 idx < mcpct_pkg::CFG_INC0 + mcpct_pkg::CHANNELS) begin
      regs.inc[idx - mcpct_pkg::CFG_INC0] = data[mcpct_pkg::TIMER_W-1:0];
    end
  endtask

  function automatic mcpct_pkg::res_t timer_step(input logic [1:0] act,
                                                 input logic [mcpct_pkg::CH_IDX_W-1:0] ch);
    mcpct_pkg::res_t                r;
    logic [mcpct_pkg::CHANNELS-1:0] hit;
    logic [3:0]                     divider;
    hit = '0;
    case (act)
      mcpct_pkg::ACT_TICK: begin
        divider = 4'd1 << regs.prescale_sel;
        if ({1'b0, presc_q} + 4'd1 >= divider) begin
          presc_q = '0;
          count_q = count_q + 1'b1;
          for (int i = 0; i < mcpct_pkg::CHANNELS; i++) begin
            if (match_at[i] == count_q) begin
              hit[i]      = 1'b1;
              match_at[i] = match_at[i] + regs.inc[i];
            end
          end
          flags_q = flags_q | hit;
        end else begin
          presc_q = presc_q + 1'b1;
        end
      end
      mcpct_pkg::ACT_ARM: begin
        if (ch < mcpct_pkg::CHANNELS) match_at[ch] = count_q + regs.inc[ch];
      end
      mcpct_pkg::ACT_CLEAR: begin
        if (ch < mcpct_pkg::CHANNELS) flags_q[ch] = 1'b0;
      end
      default: ;
    endcase
    r.count   = count_q;
    r.flags   = flags_q;
    r.matched = hit;
    r.irq     = |(flags_q & regs.irq_mask);
    return r;
  endfunction

  task automatic check_result();
    mcpct_pkg::res_t want;
    if (timer_snapshots.size() == 0) begin
      report("result with no transaction outstanding, count", 32'(out_count), 32'd0);
    end else begin
      want    = timer_snapshots.pop_front();
      checked = checked + 1;
      if (want.matched != '0) match_events = match_events + 1;
      if (out_count !== want.count) report("count", 32'(out_count), 32'(want.count));
      if (out_flags !== want.flags) report("flags", 32'(out_flags), 32'(want.flags));
      if (out_matched_now !== want.matched) begin
        report("matched_now", 32'(out_matched_now), 32'(want.matched));
      end
      if (out_irq !== want.irq) report("irq", 32'(out_irq), 32'(want.irq));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs    = '0;
      count_q = '0;
      presc_q = '0;
      flags_q = '0;
      for (int i = 0; i < mcpct_pkg::CHANNELS; i++) match_at[i] = '0;
      timer_snapshots.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) timer_snapshots.push_back(timer_step(in_action, in_channel));
      pending = timer_snapshots.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0]                      ACT_UNUSED     = 2'd3;
  localparam logic [mcpct_pkg::CFG_IDX_W-1:0] CFG_SPARE      = 3'd7;
  localparam int                              WATCHDOG_LIMIT = 2000;
  localparam int                              SETTLE_CYCLES  = 4;
  localparam int                              RANDOM_PHASES  = 8;
  localparam int                              PHASE_ITEMS    = 60;
  localparam int                              TICK_RUN       = 60;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               in_valid   = 1'b0;
  logic [1:0]                         in_action  = mcpct_pkg::ACT_TICK;
  logic [mcpct_pkg::CH_IDX_W-1:0]     in_channel = '0;
  logic                               out_stall  = 1'b0;
  logic                               cfg_valid  = 1'b0;
  logic [mcpct_pkg::CFG_IDX_W-1:0]    cfg_index  = mcpct_pkg::CFG_PRESCALE;
  logic [mcpct_pkg::CFG_DATA_W-1:0]   cfg_data   = '0;

  logic                               in_stall;
  logic                               out_valid;
  logic [mcpct_pkg::TIMER_W-1:0]      out_count;
  logic [mcpct_pkg::CHANNELS-1:0]     out_flags;
  logic [mcpct_pkg::CHANNELS-1:0]     out_matched_now;
  logic                               out_irq;
  logic                               cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int match_events;
  int idle_rate      = 0;
  int sink_burst     = 0;
  int idle_cycles    = 0;
  int items_sent     = 0;
  int settings_used  = 0;

  multi_channel_periodic_compare_timer_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_channel      (in_channel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_count       (out_count),
    .out_flags       (out_flags),
    .out_matched_now (out_matched_now),
    .out_irq         (out_irq),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  compare_timer_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_channel      (in_channel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_count       (out_count),
    .out_flags       (out_flags),
    .out_matched_now (out_matched_now),
    .out_irq         (out_irq),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .match_events    (match_events)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || idle_rate == 0) begin
      out_stall  <= 1'b0;
      sink_burst <= 0;
    end else if (sink_burst != 0) begin
      out_stall  <= 1'b1;
      sink_burst <= sink_burst - 1;
    end else if ($urandom_range(0, 15) < idle_rate) begin
      out_stall  <= 1'b1;
      sink_burst <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [mcpct_pkg::CH_IDX_W-1:0] ch);
    int gap;
    bit took;
    if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_channel <= ch;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // drain the pipe so register writes land on an idle block
  task automatic settle();
    bit idle;
    in_valid <= 1'b0;
    idle = 1'b0;
    while (!idle) begin
      @(negedge clk);
      idle = (pending == 0);
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mcpct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcpct_pkg::CFG_DATA_W-1:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
  endtask

  task automatic program_timer(
      input logic [1:0] psel,
      input logic [mcpct_pkg::CHANNELS-1:0][mcpct_pkg::TIMER_W-1:0] incs,
      input logic [mcpct_pkg::CHANNELS-1:0] mask);
    logic [15:0] junk;
    junk = 16'($urandom);
    settle();
    write_reg(mcpct_pkg::CFG_PRESCALE, {junk[15:2], psel});
    for (int i = 0; i < mcpct_pkg::CHANNELS; i++) begin
      write_reg(mcpct_pkg::CFG_INC0 + 3'(i), incs[i]);
    end
    write_reg(mcpct_pkg::CFG_IRQ_MASK, {junk[15:mcpct_pkg::CHANNELS], mask});
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic arm_all();
    for (int i = 0; i < mcpct_pkg::CHANNELS; i++) send_item(mcpct_pkg::ACT_ARM, 3'(i));
  endtask

  task automatic random_item();
    int                             pick;
    logic [mcpct_pkg::CH_IDX_W-1:0] ch;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      ch = 3'($urandom_range(mcpct_pkg::CHANNELS, 7));
    end else begin
      ch = 3'($urandom_range(0, mcpct_pkg::CHANNELS - 1));
    end
    if (pick < 62) begin
      send_item(mcpct_pkg::ACT_TICK, 3'($urandom));
    end else if (pick < 80) begin
      send_item(mcpct_pkg::ACT_ARM, ch);
    end else if (pick < 95) begin
      send_item(mcpct_pkg::ACT_CLEAR, ch);
    end else begin
      send_item(ACT_UNUSED, ch);
    end
  endtask

  function automatic logic [mcpct_pkg::TIMER_W-1:0] pick_increment();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($urandom_range(0, 12));
    if (sel == 7) return '0;
    if (sel == 8) return '1;
    return 16'($urandom);
  endfunction

  initial begin
    logic [mcpct_pkg::CHANNELS-1:0][mcpct_pkg::TIMER_W-1:0] incs;
    logic [1:0]                                             psel;
    logic [mcpct_pkg::CHANNELS-1:0]                         mask;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: arm at the current count, matches, clears, ignored codes
    idle_rate = 2;
    incs[0] = 16'd2;
    incs[1] = 16'd0;
    incs[2] = 16'hFFFF;
    incs[3] = 16'd3;
    incs[4] = 16'd1;
    program_timer(2'd0, incs, 5'h1F);
    arm_all();
    repeat (3) send_item(mcpct_pkg::ACT_TICK, 3'd0);
    send_item(mcpct_pkg::ACT_TICK, 3'd7);
    send_item(mcpct_pkg::ACT_CLEAR, 3'd4);
    send_item(mcpct_pkg::ACT_CLEAR, 3'd0);
    send_item(mcpct_pkg::ACT_CLEAR, 3'd7);
    send_item(mcpct_pkg::ACT_ARM, 3'd5);
    send_item(ACT_UNUSED, 3'd6);
    repeat (2) send_item(mcpct_pkg::ACT_TICK, 3'd0);
    send_item(mcpct_pkg::ACT_CLEAR, 3'd3);

    // shrink the divider below the running prescale count
    program_timer(2'd3, incs, 5'h1F);
    repeat (5) send_item(mcpct_pkg::ACT_TICK, 3'd0);
    program_timer(2'd1, incs, 5'h0A);
    repeat (2) send_item(mcpct_pkg::ACT_TICK, 3'd0);

    // long tick run with zero and all-ones increments
    idle_rate = 1;
    incs[0] = 16'd0;
    incs[1] = 16'hFFFF;
    incs[2] = 16'd257;
    incs[3] = 16'd4096;
    incs[4] = 16'd0;
    program_timer(2'd0, incs, 5'b10101);
    arm_all();
    for (int t = 0; t < TICK_RUN; t++) begin
      if (t % 20 == 19) begin
        send_item(mcpct_pkg::ACT_CLEAR, 3'($urandom_range(0, mcpct_pkg::CHANNELS - 1)));
      end else begin
        send_item(mcpct_pkg::ACT_TICK, 3'($urandom));
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        psel = 2'd0;
        incs = '0;
        mask = '0;
      end else if (p == 1) begin
        psel = 2'd3;
        incs = '1;
        mask = '1;
      end else begin
        psel = 2'($urandom_range(0, 3));
        for (int i = 0; i < mcpct_pkg::CHANNELS; i++) incs[i] = pick_increment();
        mask = mcpct_pkg::CHANNELS'($urandom);
      end
      program_timer(psel, incs, mask);
      idle_rate = (p == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 4);
      arm_all();
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    $display("Drove %0d timer transactions under %0d register settings.",
             items_sent, settings_used);
    $display("Compared %0d results, %0d of them carrying a compare match.",
             checked, match_events);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
